>>> sv/u2g_pkg.sv
package u2g_pkg;

	localparam int COUNT_WIDTH = 24;
	localparam int BYTE_W      = 8;
	localparam int CODE_W      = 16;
	localparam int LEN_W       = 24;
	localparam int PART_W      = 10;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TEXT = 1'b1;

	localparam logic [BYTE_W-1:0] ASCII_LIM = 8'h80;
	localparam logic [BYTE_W-1:0] LEAD2_MIN = 8'hC2;
	localparam logic [BYTE_W-1:0] LEAD3_MIN = 8'hE0;
	localparam logic [BYTE_W-1:0] LEAD4_MIN = 8'hF0;

	// table port request, one write or one read per cycle
	typedef struct packed {
		logic              we;
		logic [CODE_W-1:0] waddr;
		logic [CODE_W-1:0] wdata;
		logic              re;
		logic [CODE_W-1:0] raddr;
	} u2g_tbl_req_t;

	// decoded text request handed to the output stage
	typedef struct packed {
		logic              valid;
		logic              ascii;
		logic              look;
		logic              term;
		logic [BYTE_W-1:0] data;
	} u2g_item_t;

endpackage

>>> sv/u2g_if.sv
interface u2g_in_if;
	import u2g_pkg::*;

	logic              valid;
	logic              ready;
	logic              operation;
	logic [CODE_W-1:0] table_index;
	logic [CODE_W-1:0] table_value;
	logic [BYTE_W-1:0] text_byte;
	logic              end_of_text;

	modport source (
		output valid, operation, table_index, table_value, text_byte, end_of_text,
		input  ready
	);
	modport sink (
		input  valid, operation, table_index, table_value, text_byte, end_of_text,
		output ready
	);
endinterface

interface u2g_out_if;
	import u2g_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              is_terminator;
	logic [LEN_W-1:0]  out_length;
	logic              last_of_run;

	modport source (
		output valid, out_byte, is_terminator, out_length, last_of_run,
		input  ready
	);
	modport sink (
		input  valid, out_byte, is_terminator, out_length, last_of_run,
		output ready
	);
endinterface

>>> sv/u2g_table.sv
module u2g_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  u2g_pkg::u2g_tbl_req_t req,
	output logic [15:0]          rd_data,
	output logic                 busy
);
	import u2g_pkg::*;

	logic [CODE_W-1:0] mem_q [1 << CODE_W];
	logic [CODE_W-1:0] rd_data_q;
	logic [CODE_W-1:0] clr_addr_q;
	logic              busy_q;

	// clearing pass: one entry per cycle after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			if (clr_addr_q == '1) begin
				busy_q <= 1'b0;
			end
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem_q[clr_addr_q] <= '0;
		end else if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem_q[req.raddr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

`ifndef ASSERT_OFF
	a_clr_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && clr_addr_q != '1) |=>
			(busy_q && clr_addr_q == CODE_W'($past(clr_addr_q) + 1'b1)))
		else $error("clearing pass skipped an entry");
`endif
endmodule

>>> sv/u2g_decode.sv
module u2g_decode (
	input  logic                  clk,
	input  logic                  arst_n,
	u2g_in_if.sink                in_ch,
	input  logic                  tbl_busy,
	input  logic                  slot_free,
	output u2g_pkg::u2g_tbl_req_t tbl_req,
	output u2g_pkg::u2g_item_t    item
);
	import u2g_pkg::*;

	logic [1:0]        exp_q, exp_d;
	logic [1:0]        skip_q, skip_d;
	logic [PART_W-1:0] part_q, part_d;
	logic [BYTE_W-1:0] b;
	logic [CODE_W-1:0] code;
	logic              ascii, look, accept, is_text;

	assign in_ch.ready = !tbl_busy && slot_free;
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_text     = (in_ch.operation == OP_TEXT);
	assign b           = in_ch.text_byte;
	assign code        = {part_q, b[5:0]};

	always_comb begin
		exp_d  = exp_q;
		skip_d = skip_q;
		part_d = part_q;
		ascii  = 1'b0;
		look   = 1'b0;
		priority if (skip_q != 2'd0) begin
			skip_d = skip_q - 2'd1;
		end else if (exp_q != 2'd0) begin
			exp_d = exp_q - 2'd1;
			if (exp_q == 2'd1) begin
				look   = 1'b1;
				part_d = '0;
			end else begin
				part_d = code[PART_W-1:0];
			end
		end else if (b < ASCII_LIM) begin
			ascii = 1'b1;
		end else if (b < LEAD2_MIN) begin
			// stray continuation or overlong lead: dropped
			part_d = part_q;
		end else if (b < LEAD3_MIN) begin
			part_d = {5'd0, b[4:0]};
			exp_d  = 2'd1;
		end else if (b < LEAD4_MIN) begin
			part_d = {6'd0, b[3:0]};
			exp_d  = 2'd2;
		end else begin
			skip_d = 2'd3;
		end
		if (in_ch.end_of_text) begin
			exp_d  = '0;
			skip_d = '0;
			part_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_q  <= '0;
			skip_q <= '0;
			part_q <= '0;
		end else if (accept && is_text) begin
			exp_q  <= exp_d;
			skip_q <= skip_d;
			part_q <= part_d;
		end
	end

	always_comb begin
		tbl_req.we    = accept && !is_text;
		tbl_req.waddr = in_ch.table_index;
		tbl_req.wdata = in_ch.table_value;
		tbl_req.re    = accept && is_text && look;
		tbl_req.raddr = code;

		item.valid = accept && is_text && (ascii || look || in_ch.end_of_text);
		item.ascii = ascii;
		item.look  = look;
		item.term  = in_ch.end_of_text;
		item.data  = b;
	end
endmodule

>>> sv/u2g_emit.sv
module u2g_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  u2g_pkg::u2g_item_t item,
	input  logic [15:0]        rd_data,
	output logic               slot_free,
	u2g_out_if.source          out_ch
);
	import u2g_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	logic                   v_s1, ascii_s1, look_s1, term_s1;
	logic [BYTE_W-1:0]      data_s1;
	logic [1:0]             step_q;
	logic [COUNT_WIDTH-1:0] count_q;

	logic                   ovalid_q, oterm_q, olast_q;
	logic [BYTE_W-1:0]      obyte_q;
	logic [LEN_W-1:0]       olen_q;

	logic                   gv, move, last, done, cur_term;
	logic [1:0]             n;
	logic [BYTE_W-1:0]      cur_byte;

	assign gv = look_s1 && (rd_data != '0);
	assign n  = {1'b0, ascii_s1} + {gv, 1'b0} + {1'b0, term_s1};

	// results of one request: [ascii | gbk hi, gbk lo] then terminator
	always_comb begin
		cur_byte = '0;
		cur_term = 1'b0;
		if (ascii_s1) begin
			if (step_q == 2'd0) begin
				cur_byte = data_s1;
			end else begin
				cur_term = 1'b1;
			end
		end else if (gv) begin
			unique case (step_q)
				2'd0:    cur_byte = rd_data[15:8];
				2'd1:    cur_byte = rd_data[7:0];
				default: cur_term = 1'b1;
			endcase
		end else begin
			cur_term = 1'b1;
		end
	end

	assign move      = v_s1 && (n != 2'd0) && (!ovalid_q || out_ch.ready);
	assign last      = (step_q == n - 2'd1);
	assign done      = v_s1 && ((n == 2'd0) || (move && last));
	assign slot_free = !v_s1 || done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			step_q   <= '0;
			count_q  <= '0;
			ovalid_q <= 1'b0;
		end else begin
			if (slot_free) begin
				v_s1 <= item.valid;
			end
			if (done) begin
				step_q <= '0;
			end else if (move) begin
				step_q <= step_q + 2'd1;
			end
			if (move) begin
				if (cur_term) begin
					count_q <= '0;
				end else if (count_q != COUNT_MAX) begin
					count_q <= count_q + 1'b1;
				end
			end
			if (move) begin
				ovalid_q <= 1'b1;
			end else if (out_ch.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && item.valid) begin
			ascii_s1 <= item.ascii;
			look_s1  <= item.look;
			term_s1  <= item.term;
			data_s1  <= item.data;
		end
		if (move) begin
			obyte_q <= cur_byte;
			oterm_q <= cur_term;
			olen_q  <= cur_term ? LEN_W'(count_q) : '0;
			olast_q <= last;
		end
	end

	assign out_ch.valid         = ovalid_q;
	assign out_ch.out_byte      = obyte_q;
	assign out_ch.is_terminator = oterm_q;
	assign out_ch.out_length    = olen_q;
	assign out_ch.last_of_run   = olast_q;

`ifndef ASSERT_OFF
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && n != 2'd0) |-> (step_q < n))
		else $error("result index past end of request");
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && oterm_q) |-> olast_q)
		else $error("terminator not flagged last");
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(move && !cur_term && count_q == COUNT_MAX) |=> (count_q == COUNT_MAX))
		else $error("output count wrapped");
`endif
endmodule

>>> sv/utf8_to_gbk_transcoder_core.sv
// UTF-8 to GBK transcoder.
// in_ch (valid/ready): operation 0 writes table_value into the 64K-entry code
// table at table_index; operation 1 delivers one text byte, end_of_text marks
// the last byte of a string. out_ch (valid/ready) carries up to three results
// per request: a GBK byte, or a terminator with the string's byte count in
// out_length; last_of_run flags the final result of an input request.
// The table read and the staging register load at the accepting edge; the
// output register then loads the first result of a text byte once out_ch has
// room for it.
// Throughput: one request per cycle while out_ch is ready and each produces at
// most one result; a request with k results (max 3) holds the output stage
// until all have left, since the output register moves one result per cycle.
// Reset: the text state and counters clear at once, then a clearing pass
// zeroes the table one entry per cycle, and in_ch.ready stays low during the
// pass. When out_ch stalls, the output register holds its result, and the
// staged request and in_ch.ready back up behind it.
module utf8_to_gbk_transcoder_core (
	input  logic      clk,
	input  logic      arst_n,
	u2g_in_if.sink    in_ch,
	u2g_out_if.source out_ch
);
	import u2g_pkg::*;

	u2g_tbl_req_t      tbl_req;
	u2g_item_t         item;
	logic [CODE_W-1:0] rd_data;
	logic              tbl_busy, slot_free;

	u2g_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tbl_req),
		.rd_data (rd_data),
		.busy    (tbl_busy)
	);

	u2g_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.tbl_busy  (tbl_busy),
		.slot_free (slot_free),
		.tbl_req   (tbl_req),
		.item      (item)
	);

	u2g_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.rd_data   (rd_data),
		.slot_free (slot_free),
		.out_ch    (out_ch)
	);

`ifndef ASSERT_OFF
	a_no_accept_clr: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_busy |-> !in_ch.ready)
		else $error("request taken during table clear");
`endif
endmodule

>>> tb/u2g_tb_pkg.sv
`timescale 1ns / 1ps
package u2g_tb_pkg;
	import u2g_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              is_terminator;
		logic [LEN_W-1:0]  out_length;
		logic              last_of_run;
	} gbk_result_t;

	class gbk_scoreboard;
		bit [CODE_W-1:0]      code_map [0:65535];
		bit [1:0]             cont_left;
		bit [1:0]             skip_left;
		bit [PART_W-1:0]      code_bits;
		bit [COUNT_WIDTH-1:0] emitted;
		gbk_result_t          run_q[$];
		gbk_result_t          gbk_q[$];
		int unsigned          failures;

		function int pending();
			return gbk_q.size();
		endfunction

		function void report(string msg);
			failures++;
			if (failures <= 10)
				$display("%0t: %s", $time, msg);
		endfunction

		function void add_byte(logic [BYTE_W-1:0] b);
			gbk_result_t r;
			r = '0;
			r.out_byte = b;
			run_q.push_back(r);
			if (emitted != '1)
				emitted++;
		endfunction

		// expected GBK bytes and terminator for one accepted request; a load only updates the code map
		function void note_request(logic op, logic [CODE_W-1:0] idx, logic [CODE_W-1:0] val,
				logic [BYTE_W-1:0] b, logic eot);
			logic [CODE_W-1:0] code;
			logic [CODE_W-1:0] gbk;
			gbk_result_t       r;
			if (op == OP_LOAD) begin
				code_map[idx] = val;
				return;
			end
			run_q.delete();
			if (skip_left != 0) begin
				skip_left--;
			end else if (cont_left != 0) begin
				// continuation taken as is, only its low six bits count
				code = {code_bits, b[5:0]};
				cont_left--;
				if (cont_left == 0) begin
					gbk = code_map[code];
					code_bits = '0;
					if (gbk != 0) begin
						add_byte(gbk[15:8]);
						add_byte(gbk[7:0]);
					end
				end else begin
					code_bits = code[PART_W-1:0];
				end
			end else if (b < ASCII_LIM) begin
				add_byte(b);
			end else if (b < LEAD2_MIN) begin
				// stray continuation or overlong lead: dropped
			end else if (b < LEAD3_MIN) begin
				code_bits = {5'b0, b[4:0]};
				cont_left = 2'd1;
			end else if (b < LEAD4_MIN) begin
				code_bits = {6'b0, b[3:0]};
				cont_left = 2'd2;
			end else begin
				skip_left = 2'd3;
			end
			if (eot) begin
				r = '0;
				r.is_terminator = 1'b1;
				r.out_length = LEN_W'(emitted);
				run_q.push_back(r);
				cont_left = '0;
				skip_left = '0;
				code_bits = '0;
				emitted = '0;
			end
			if (run_q.size() != 0) begin
				r = run_q.pop_back();
				r.last_of_run = 1'b1;
				run_q.push_back(r);
			end
			foreach (run_q[i])
				gbk_q.push_back(run_q[i]);
		endfunction

		function void check_result(logic [BYTE_W-1:0] b, logic term, logic [LEN_W-1:0] len,
				logic last);
			gbk_result_t want;
			if (gbk_q.size() == 0) begin
				report($sformatf("unexpected result: byte %h term %b len %0d last %b",
					b, term, len, last));
				return;
			end
			want = gbk_q.pop_front();
			if (b !== want.out_byte || term !== want.is_terminator ||
					len !== want.out_length || last !== want.last_of_run)
				report($sformatf("mismatch: want byte %h term %b len %0d last %b, got byte %h term %b len %0d last %b",
					want.out_byte, want.is_terminator, want.out_length, want.last_of_run,
					b, term, len, last));
		endfunction
	endclass

endpackage

>>> tb/tb_utf8_to_gbk_transcoder_core.sv
`timescale 1ns / 1ps
module tb_utf8_to_gbk_transcoder_core;
	import u2g_pkg::*;
	import u2g_tb_pkg::*;

	localparam int LIMIT_CYCLES  = 600000;
	localparam int HOLD_CYCLES   = 400;
	localparam int SETTLE_CYCLES = 20;
	localparam int RANDOM_ITEMS  = 380;
	localparam int POOL_MAX      = 48;

	logic clk = 1'b0;
	logic arst_n;

	u2g_in_if  in_ch ();
	u2g_out_if out_ch ();

	gbk_scoreboard   sb = new();
	bit [CODE_W-1:0] mapped_codes[$];
	int unsigned     src_idle_pct;
	int unsigned     sink_stall_pct;
	int unsigned     items_sent;
	int unsigned     cycle_count;
	int unsigned     hold_left;
	bit              hold_req;
	bit              hold_ack;

	utf8_to_gbk_transcoder_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// output side: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
		if (arst_n && out_ch.valid && out_ch.ready)
			sb.check_result(out_ch.out_byte, out_ch.is_terminator, out_ch.out_length,
				out_ch.last_of_run);
	end

	function automatic bit end_draw();
		return $urandom_range(99) < 8;
	endfunction

	task automatic send_item(input logic op, input logic [CODE_W-1:0] idx,
			input logic [CODE_W-1:0] val, input logic [BYTE_W-1:0] b, input logic eot);
		while ($urandom_range(99) < src_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.operation <= op;
		in_ch.table_index <= idx;
		in_ch.table_value <= val;
		in_ch.text_byte <= b;
		in_ch.end_of_text <= eot;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_request(op, idx, val, b, eot);
		items_sent++;
	endtask

	task automatic send_load(input logic [CODE_W-1:0] idx, input logic [CODE_W-1:0] val);
		send_item(OP_LOAD, idx, val, BYTE_W'($urandom()), 1'($urandom()));
		if (val != 0) begin
			mapped_codes.push_back(idx);
			if (mapped_codes.size() > POOL_MAX)
				void'(mapped_codes.pop_front());
		end
	endtask

	task automatic send_text(input logic [BYTE_W-1:0] b, input logic eot);
		send_item(OP_TEXT, CODE_W'($urandom()), CODE_W'($urandom()), b, eot);
	endtask

	// one code point as a 2- or 3-byte sequence, now and then with a
	// malformed continuation in the middle
	task automatic send_char(input logic [CODE_W-1:0] code, input logic eot);
		logic [1:0] top;
		top = ($urandom_range(7) == 0) ? 2'($urandom()) : 2'b10;
		if (code >= 16'h0080 && code <= 16'h07FF && $urandom_range(1) == 1) begin
			send_text({3'b110, code[10:6]}, 1'b0);
			send_text({2'b10, code[5:0]}, eot);
		end else begin
			send_text({4'b1110, code[15:12]}, 1'b0);
			send_text({top, code[11:6]}, 1'b0);
			send_text({2'b10, code[5:0]}, eot);
		end
	endtask

	task automatic send_random_unit();
		int unsigned     sel;
		logic [CODE_W-1:0] code;
		sel = $urandom_range(99);
		if (sel < 12) begin
			code = ($urandom_range(1) == 1) ? CODE_W'($urandom_range(16'h07FF, 16'h0080))
				: CODE_W'($urandom());
			send_load(code, ($urandom_range(9) == 0) ? '0 : CODE_W'($urandom()));
		end else if (sel < 40) begin
			send_text(BYTE_W'($urandom_range(127)), end_draw());
		end else if (sel < 75) begin
			if (mapped_codes.size() != 0)
				code = mapped_codes[$urandom_range(mapped_codes.size() - 1)];
			else
				code = CODE_W'($urandom());
			send_char(code, end_draw());
		end else if (sel < 85) begin
			send_text(BYTE_W'($urandom_range(255, 240)), 1'b0);
			send_text({2'b10, 6'($urandom())}, 1'b0);
			send_text({2'b10, 6'($urandom())}, 1'b0);
			send_text({2'b10, 6'($urandom())}, end_draw());
		end else begin
			send_text(BYTE_W'($urandom()), end_draw());
		end
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic run_directed();
		send_load(16'h4E2D, 16'hD6D0);
		send_load(16'hFFFF, 16'hFFFF);
		send_load(16'h0080, 16'h0001);
		send_load(16'h0000, 16'h1234);
		send_text(8'h00, 1'b0);
		send_text(8'h7F, 1'b0);
		send_text(8'h80, 1'b0);
		send_text(8'hC1, 1'b0);
		send_text(8'hC2, 1'b0);
		send_text(8'h80, 1'b0);
		// two GBK bytes plus terminator from one request
		send_text(8'hE4, 1'b0);
		send_text(8'hB8, 1'b0);
		send_text(8'hAD, 1'b1);
		send_text(8'hEF, 1'b0);
		send_text(8'hBF, 1'b0);
		send_text(8'hBF, 1'b0);
		// ASCII bytes where continuations belong, code 0
		send_text(8'hE0, 1'b0);
		send_text(8'h00, 1'b0);
		send_text(8'h00, 1'b0);
		send_text(8'hF0, 1'b0);
		send_text(8'h41, 1'b0);
		send_text(8'h42, 1'b0);
		send_text(8'h43, 1'b0);
		// string ends inside a sequence, then inside a skip
		send_text(8'hE4, 1'b0);
		send_text(8'hB8, 1'b1);
		send_text(8'hFF, 1'b0);
		send_text(8'h41, 1'b1);
	endtask

	initial begin
		int unsigned phase_end;
		bit          held;
		bit          paused;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.operation <= OP_TEXT;
		in_ch.table_index <= '0;
		in_ch.table_value <= '0;
		in_ch.text_byte <= '0;
		in_ch.end_of_text <= 1'b0;
		src_idle_pct = 0;
		sink_stall_pct <= 0;
		held = 1'b0;
		paused = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		run_directed();
		drain();

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct <= 0;
				end
				1: begin
					src_idle_pct = 45;
					sink_stall_pct <= 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct <= 45;
				end
				default: begin
					src_idle_pct = 19;
					sink_stall_pct <= 19;
				end
			endcase
			phase_end = items_sent + RANDOM_ITEMS / 4;
			while (items_sent < phase_end) begin
				// output held off while requests keep coming, so the block backs up
				if (p == 0 && !held && items_sent + 70 >= phase_end) begin
					hold_req <= ~hold_req;
					held = 1'b1;
				end
				if (p == 2 && !paused && items_sent + 45 >= phase_end) begin
					drain();
					paused = 1'b1;
				end
				send_random_unit();
			end
			drain();
		end

		if (sb.failures == 0 && sb.pending() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

>>> utf8_to_gbk_transcoder_core.f
sv/u2g_pkg.sv
sv/u2g_if.sv
sv/u2g_table.sv
sv/u2g_decode.sv
sv/u2g_emit.sv
sv/utf8_to_gbk_transcoder_core.sv
tb/u2g_tb_pkg.sv
tb/tb_utf8_to_gbk_transcoder_core.sv
